### rtl/cha_pkg.sv
// Shared types and constants for the ChaCha round permutation block.
// Used by cha_ctrl, cha_dp and chacha_round_permutation; no dependencies.
`default_nettype none

package cha_pkg;

    localparam int          NUM_WORDS  = 16;
    localparam int          WORD_W     = 32;
    localparam int          CFG_IDX_W  = 8;
    localparam logic [4:0]  MAX_ROUNDS = 5'd20;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_IS_DIAGONAL = 8'd2;

    // Configuration register contents
    typedef struct packed {
        logic [4:0] round_count;
        logic       inverse_mode;
        logic       first_is_diagonal;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // shift one loaded word in at the top
        logic       shift_out;  // drop word 0, move the rest down
        logic       step_en;    // apply one quarter-round step to all four groups
        logic [1:0] step;       // which line of the quarter round
        logic       inv;        // inverse quarter-round step
        logic       diag;       // diagonal groups, else column groups
    } t_dp_cmd;

endpackage

`default_nettype wire

### rtl/cha_dp.sv
// Datapath: sixteen 32-bit state words and four quarter-round step units.
// Depends on cha_pkg for the command struct and widths.
`default_nettype none

module cha_dp (
    input  wire logic                  i_clk,
    input  wire cha_pkg::t_dp_cmd      i_cmd,
    input  wire logic [31:0]           i_state_word,
    output logic [31:0]                o_word0
);

    logic [31:0] r_s [cha_pkg::NUM_WORDS];
    logic [31:0] n_s [cha_pkg::NUM_WORDS];

    // One quarter-round line per cycle for each of the four groups; the groups
    // of a round are disjoint, so they run side by side.
    always_comb begin
        logic [31:0] a, b, c, d;
        logic [3:0]  ia, ib, ic, id;
        for (int i = 0; i < cha_pkg::NUM_WORDS; i++) begin
            n_s[i] = r_s[i];
        end
        for (int q = 0; q < 4; q++) begin
            ia = 4'(q);
            ib = 4'(4  + ((q + (i_cmd.diag ? 1 : 0)) % 4));
            ic = 4'(8  + ((q + (i_cmd.diag ? 2 : 0)) % 4));
            id = 4'(12 + ((q + (i_cmd.diag ? 3 : 0)) % 4));
            a = r_s[ia];
            b = r_s[ib];
            c = r_s[ic];
            d = r_s[id];
            if (!i_cmd.inv) begin
                case (i_cmd.step)
                    2'd0: begin
                        a = a + b;
                        d = d ^ a;
                        d = {d[15:0], d[31:16]};
                    end
                    2'd1: begin
                        c = c + d;
                        b = b ^ c;
                        b = {b[19:0], b[31:20]};
                    end
                    2'd2: begin
                        a = a + b;
                        d = d ^ a;
                        d = {d[23:0], d[31:24]};
                    end
                    default: begin
                        c = c + d;
                        b = b ^ c;
                        b = {b[24:0], b[31:25]};
                    end
                endcase
            end else begin
                case (i_cmd.step)
                    2'd0: begin
                        b = {b[6:0], b[31:7]} ^ c;
                        c = c - d;
                    end
                    2'd1: begin
                        d = {d[7:0], d[31:8]} ^ a;
                        a = a - b;
                    end
                    2'd2: begin
                        b = {b[11:0], b[31:12]} ^ c;
                        c = c - d;
                    end
                    default: begin
                        d = {d[15:0], d[31:16]} ^ a;
                        a = a - b;
                    end
                endcase
            end
            n_s[ia] = a;
            n_s[ib] = b;
            n_s[ic] = c;
            n_s[id] = d;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < cha_pkg::NUM_WORDS - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
            r_s[cha_pkg::NUM_WORDS-1] <= i_state_word;
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < cha_pkg::NUM_WORDS - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
        end else if (i_cmd.step_en) begin
            for (int i = 0; i < cha_pkg::NUM_WORDS; i++) begin
                r_s[i] <= n_s[i];
            end
        end
    end

    assign o_word0 = r_s[0];

endmodule

`default_nettype wire

### rtl/cha_ctrl.sv
// Controller: load, round and emit sequencing for the ChaCha round block.
// Depends on cha_pkg for the configuration and command structs.
`default_nettype none

module cha_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cha_pkg::t_cfg     i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_result_last,
    output cha_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_EMIT
    } t_state;

    t_state      r_state;
    logic [3:0]  r_load_cnt;
    logic [3:0]  r_emit_cnt;
    logic [4:0]  r_round;
    logic [4:0]  r_final;
    logic [1:0]  r_step;
    logic        r_inv;
    logic        r_fid;

    logic        in_acc;
    logic        out_acc;
    logic [4:0]  n_rounds;

    assign in_acc   = i_in_valid && (r_state == ST_LOAD);
    assign out_acc  = i_out_ready && (r_state == ST_EMIT);
    assign n_rounds = (i_cfg.round_count > cha_pkg::MAX_ROUNDS) ? cha_pkg::MAX_ROUNDS
                                                                : i_cfg.round_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_emit_cnt <= '0;
            r_round    <= '0;
            r_final    <= '0;
            r_step     <= '0;
            r_inv      <= 1'b0;
            r_fid      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_load_cnt <= r_load_cnt + 4'd1;
                        if (r_load_cnt == 4'd15) begin
                            // sample the registers with the last word
                            r_inv   <= i_cfg.inverse_mode;
                            r_fid   <= i_cfg.first_is_diagonal;
                            r_step  <= '0;
                            r_round <= i_cfg.inverse_mode ? n_rounds - 5'd1 : 5'd0;
                            r_final <= i_cfg.inverse_mode ? 5'd0 : n_rounds - 5'd1;
                            r_state <= (n_rounds == 5'd0) ? ST_EMIT : ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        if (r_round == r_final) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_round <= r_inv ? r_round - 5'd1 : r_round + 5'd1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        r_emit_cnt <= r_emit_cnt + 4'd1;
                        if (r_emit_cnt == 4'd15) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_in_ready    = (r_state == ST_LOAD);
    assign o_out_valid   = (r_state == ST_EMIT);
    assign o_result_last = (r_emit_cnt == 4'd15);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = in_acc;
        o_cmd.shift_out = out_acc;
        o_cmd.step_en   = (r_state == ST_ROUND);
        o_cmd.step      = r_inv ? r_step : r_step;
        o_cmd.inv       = r_inv;
        o_cmd.diag      = r_round[0] ^ r_fid;
    end

endmodule

`default_nettype wire

### rtl/chacha_round_permutation.sv
// ChaCha round permutation: 16 loads, then the rounds, then 16 emits. The round
// count is round_count saturated at 20; a new block loads only after all 16
// results of the last one are taken. Synchronous active-low reset clears
// the controller and sets round_count 20, inverse_mode 0, first_is_diagonal 0.
`default_nettype none

module chacha_round_permutation (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cha_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    // input items
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [31:0]                    i_state_word,
    // result items
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [31:0]                         o_result_word,
    output logic                                o_result_last
);

    cha_pkg::t_cfg    r_cfg;
    cha_pkg::t_dp_cmd cmd;

    // Registers are always writable; writes must happen only while the block is idle, which the block does not enforce.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.round_count       <= cha_pkg::MAX_ROUNDS;
            r_cfg.inverse_mode      <= 1'b0;
            r_cfg.first_is_diagonal <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cha_pkg::CFG_ROUND_COUNT:       r_cfg.round_count       <= i_cfg_data[4:0];
                cha_pkg::CFG_INVERSE_MODE:      r_cfg.inverse_mode      <= i_cfg_data[0];
                cha_pkg::CFG_FIRST_IS_DIAGONAL: r_cfg.first_is_diagonal <= i_cfg_data[0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Sequencing: load count, round/step counters, emit count
    cha_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_last (o_result_last),
        .o_cmd         (cmd)
    );

    // State words shift in on load, step through the rounds, shift out on emit
    cha_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_state_word (i_state_word),
        .o_word0      (o_result_word)
    );

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides open at once");

    // A block's first result is never marked last.
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_result_last)
        else $error("first result of a block marked last");

    // Taking the last result reopens the input side.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_result_last) |=> (o_in_ready && !o_out_valid))
        else $error("input side not reopened after last result");

endmodule

`default_nettype wire

### test/tb_cha_pkg.sv
// Scoreboard class for the ChaCha round permutation testbench: predicts each
// 16-word block and checks result words in order. Depends on rtl/cha_pkg.sv.
package tb_cha_pkg;

    import cha_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_result_item;

    class chacha_block_check;

        logic [WORD_W-1:0] words [NUM_WORDS];
        int unsigned       fill;
        logic [4:0]        rounds;
        bit                inverse;
        bit                diag_first;
        t_result_item      words_due [$];
        int unsigned       errors;

        function new();
            fill       = 0;
            rounds     = 5'd20;
            inverse    = 1'b0;
            diag_first = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return words_due.size();
        endfunction

        // Mirror a register write; unknown indexes are dropped.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_ROUND_COUNT:       rounds     = data[4:0];
                CFG_INVERSE_MODE:      inverse    = data[0];
                CFG_FIRST_IS_DIAGONAL: diag_first = data[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void quarter(int ia, int ib, int ic, int id, bit inv);
            logic [31:0] a, b, c, d;
            a = words[ia]; b = words[ib]; c = words[ic]; d = words[id];
            if (inv) begin
                b = rotl(b, 25) ^ c; c = c - d;
                d = rotl(d, 24) ^ a; a = a - b;
                b = rotl(b, 20) ^ c; c = c - d;
                d = rotl(d, 16) ^ a; a = a - b;
            end else begin
                a = a + b; d = rotl(d ^ a, 16);
                c = c + d; b = rotl(b ^ c, 12);
                a = a + b; d = rotl(d ^ a, 8);
                c = c + d; b = rotl(b ^ c, 7);
            end
            words[ia] = a; words[ib] = b; words[ic] = c; words[id] = d;
        endfunction

        // Forward round r is diagonal when bit 0 of r differs from diag_first.
        function void apply_round(int r, bit inv);
            bit diag;
            int g;
            diag = r[0] ^ diag_first;
            for (int q = 0; q < 4; q++) begin
                g = inv ? 3 - q : q;
                if (diag)
                    quarter(g, 4 + (g + 1) % 4, 8 + (g + 2) % 4, 12 + (g + 3) % 4, inv);
                else
                    quarter(g, g + 4, g + 8, g + 12, inv);
            end
        endfunction

        function void permute_block();
            int n;
            n = (rounds > MAX_ROUNDS) ? int'(MAX_ROUNDS) : int'(rounds);
            if (inverse) begin
                for (int r = n - 1; r >= 0; r--)
                    apply_round(r, 1'b1);
            end else begin
                for (int r = 0; r < n; r++)
                    apply_round(r, 1'b0);
            end
        endfunction

        // Take one accepted input item; a full block queues sixteen results.
        function void note_word(logic [WORD_W-1:0] w);
            t_result_item item;
            words[fill] = w;
            if (fill < NUM_WORDS - 1) begin
                fill++;
                return;
            end
            fill = 0;
            permute_block();
            for (int k = 0; k < NUM_WORDS; k++) begin
                item.word = words[k];
                item.last = (k == NUM_WORDS - 1);
                words_due.push_back(item);
            end
        endfunction

        function void check_result(logic [WORD_W-1:0] word, logic last);
            t_result_item item;
            if (words_due.size() == 0) begin
                $error("result with nothing due: result_word %h result_last %b", word, last);
                errors++;
                return;
            end
            item = words_due.pop_front();
            if (word !== item.word) begin
                $error("result_word: expected %h, got %h", item.word, word);
                errors++;
            end
            if (last !== item.last) begin
                $error("result_last: expected %b, got %b", item.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

### test/tb_top.sv
// Top-level testbench for chacha_round_permutation: drives 16-word blocks and
// register writes, checks every result word. Depends on cha_pkg and tb_cha_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cha_pkg::*;
    import tb_cha_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 8;
    localparam int DRAIN       = 4 * 20 + 40;
    localparam int HOLD_CYCLES = 400;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [31:0]          cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic [WORD_W-1:0]    in_word     = '0;
    logic                 out_ready   = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [WORD_W-1:0]    o_result_word;
    logic                 o_result_last;

    // Set by the stimulus: steady turns off idling on both sides, hold_req asks
    // the receiver for one long hold-off.
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    chacha_block_check sb = new();

    chacha_round_permutation DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_state_word  (in_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_result_word (o_result_word),
        .o_result_last (o_result_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort on a hung handshake.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_top: errors");
        $finish;
    end

    // Receiver: check the item taken at this edge, then pick ready for the
    // next cycle. A hold-off request drops ready until hold_left, loaded from HOLD_CYCLES, runs out.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && out_ready)
                sb.check_result(o_result_word, o_result_last);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(99) >= 26);
            end
        end
    end

    // Offer one item; leave valid high so the next item can follow at once.
    task automatic send_word(input logic [WORD_W-1:0] w);
        while (!steady && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    // Write one register; valid stays up until the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Program all three registers; junk in the upper data bits must be ignored.
    task automatic configure(input logic [4:0] rc, input bit inv, input bit diag);
        write_reg(CFG_ROUND_COUNT, {27'($urandom()), rc});
        write_reg(CFG_INVERSE_MODE, {31'($urandom()), inv});
        write_reg(CFG_FIRST_IS_DIAGONAL, {31'($urandom()), diag});
        cfg_valid <= 1'b0;
    endtask

    // Wait for every due result, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] bit_mask;
        bit_mask = 32'h1 << $urandom_range(31);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return bit_mask;
            3:       return ~bit_mask;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [4:0] rc;
        bit         inv;
        bit         diag;
        int         blocks;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: alternate all-zero and all-one words, 20 forward rounds.
        for (int k = 0; k < NUM_WORDS; k++)
            send_word(k[0] ? '1 : '0);
        wait_idle();

        // Load half a block, rewrite registers mid-load, then finish the block:
        // the registers count when the sixteenth word arrives, so it passes through.
        for (int k = 0; k < NUM_WORDS / 2; k++)
            send_word(32'h8000_0000 >> k);
        wait_idle();
        configure(5'd0, 1'b1, 1'b1);
        // Out-of-range indexes: drop silently.
        write_reg(CFG_FIRST_IS_DIAGONAL + 8'd1, 32'hFFFF_FFFF);
        write_reg('1, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        for (int k = NUM_WORDS / 2; k < NUM_WORDS; k++)
            send_word(~(32'h1 << k));
        wait_idle();

        // Random phases: extremes of the round count first, then random settings.
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0:       rc = 5'd31;
                1:       rc = 5'd20;
                2:       rc = 5'd1;
                3:       rc = 5'd21;
                default: rc = 5'($urandom_range(31));
            endcase
            inv  = (phase < 4) ? phase[0] : 1'($urandom_range(1));
            diag = (phase < 4) ? phase[1] : 1'($urandom_range(1));
            configure(rc, inv, diag);
            steady = (phase == 6 || phase == 7);
            // Phase 3: stall the output long enough to back up the input.
            if (phase == 3)
                hold_req = 1'b1;
            blocks = (phase == 3) ? 3 : 1;
            for (int b = 0; b < blocks * NUM_WORDS; b++)
                send_word(rand_word());
            wait_idle();
        end
        steady = 1'b0;

        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
